/* design/gtbd_pkg.sv */
// Shared types and constants for the gap tolerant blob detector.
// No dependencies; the queue, front, back and top use it by scoped names.
package gtbd_pkg;

   // Configuration register indexes (word address = index)
   localparam logic [2:0] REG_FILTER_PEAK = 3'd0;
   localparam logic [2:0] REG_DOUBLE_PEAK = 3'd1;
   localparam logic [2:0] REG_BAND_FLOOR  = 3'd2;
   localparam logic [2:0] REG_GAP_MAX     = 3'd3;
   localparam logic [2:0] REG_MIN_DENSITY = 3'd4;

   localparam logic [9:0]  GAP_MAX_RESET = 10'd4;
   localparam logic [25:0] SUM26_MAX     = '1;
   localparam logic [26:0] SUM27_MAX     = '1;
   localparam logic [47:0] SUM48_MAX     = '1;
   localparam logic [10:0] CNT11_MAX     = '1;
   localparam logic [15:0] MEAN_MAX      = '1;
   localparam logic [9:0]  LOC_MAX       = '1;

   typedef struct packed {
      logic [15:0] filter_peak;
      logic [16:0] double_peak;
      logic [15:0] band_floor;
      logic [9:0]  gap_max;
      logic [15:0] keep_threshold;
   } cfg_type;

   // One record per accepted sample, front to back
   typedef struct packed {
      logic        pass_start;
      logic        close;
      logic [26:0] weight_sum;
      logic [47:0] moment_sum;
      logic [10:0] sample_count;
      logic [10:0] run_width;
      logic [25:0] total_sum;
      logic [15:0] running_peak;
   } job_type;

   typedef struct packed {
      logic        blob_valid;
      logic [2:0]  blob_slot;
      logic [15:0] blob_peak;
      logic [15:0] blob_density;
      logic [9:0]  blob_location;
      logic [10:0] blob_width;
      logic        slots_full;
      logic [25:0] density_total;
      logic [25:0] blob_mean_total;
      logic [15:0] peak_value;
   } rsp_type;

   // Line store read request from back to front
   typedef struct packed {
      logic       rd_en;
      logic [9:0] rd_addr;
   } mem_req_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_MEAN,
      B_LOC,
      B_READ
   } back_state_type;

endpackage

/* design/gtbd_if.sv */
// Sample and result channel interfaces (valid/ready plus payload).
// Depends on nothing; used by the front, back and top level.
interface gtbd_req_if;
   logic        valid;
   logic        ready;
   logic        pass_start;
   logic [9:0]  position;
   logic [15:0] map_value;
   logic [15:0] background_value;

   modport source (output valid, pass_start, position, map_value, background_value,
                   input ready);
   modport sink (input valid, pass_start, position, map_value, background_value,
                 output ready);
endinterface

interface gtbd_rsp_if;
   logic        valid;
   logic        ready;
   logic        blob_valid;
   logic [2:0]  blob_slot;
   logic [15:0] blob_peak;
   logic [15:0] blob_density;
   logic [9:0]  blob_location;
   logic [10:0] blob_width;
   logic        slots_full;
   logic [25:0] density_total;
   logic [25:0] blob_mean_total;
   logic [15:0] peak_value;

   modport source (output valid, blob_valid, blob_slot, blob_peak, blob_density,
                   blob_location, blob_width, slots_full, density_total,
                   blob_mean_total, peak_value, input ready);
   modport sink (input valid, blob_valid, blob_slot, blob_peak, blob_density,
                 blob_location, blob_width, slots_full, density_total,
                 blob_mean_total, peak_value, output ready);
endinterface

/* design/gtbd_div.sv */
// Serial restoring divider, one quotient bit per cycle.
// Depends on nothing; the back end shares it for mean and centroid.
module gtbd_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [47:0] dividend,
   input  logic [26:0] divisor,
   output logic        done,
   output logic [47:0] quotient
);

   logic [47:0] q_ff, q_in;
   logic [26:0] r_ff, r_in;
   logic [26:0] d_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff, done_ff, zero_ff;
   logic [27:0] trial;

   // one restoring step
   always_comb begin
      trial = {r_ff, q_ff[47]};
      if (trial >= {1'b0, d_ff}) begin
         r_in = 27'(trial - {1'b0, d_ff});
         q_in = {q_ff[46:0], 1'b1};
      end else begin
         r_in = trial[26:0];
         q_in = {q_ff[46:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd47) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff    <= dividend;
         r_ff    <= '0;
         d_ff    <= divisor;
         zero_ff <= (divisor == '0);
      end else if (busy_ff) begin
         q_ff <= q_in;
         r_ff <= r_in;
      end
   end

   // zero divisor reads as zero
   assign done     = done_ff;
   assign quotient = zero_ff ? '0 : q_ff;

endmodule

/* design/gtbd_queue.sv */
// Two-entry job queue between the front and back ends.
// Depends on gtbd_pkg for the job record.
module gtbd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  gtbd_pkg::job_type push_job,
   output logic              not_full,
   input  logic              pop,
   output logic              not_empty,
   output gtbd_pkg::job_type head_job
);

   gtbd_pkg::job_type slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign not_full  = (count_ff != 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head_job  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_job;
   end

endmodule

/* design/gtbd_front.sv */
// Front end: accepts samples, keeps the line store, running sums and the
// open blob's accumulators, and queues one job per sample. Uses gtbd_pkg.
module gtbd_front #(
   parameter int PROFILE_LEN  = 1024,
   parameter int DENSITY_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   gtbd_req_if.sink              req,
   input  gtbd_pkg::cfg_type     cfg,
   output logic                  push,
   output gtbd_pkg::job_type     push_job,
   input  logic                  q_not_full,
   input  logic                  close_done,
   input  gtbd_pkg::mem_req_type mem_req,
   output logic [15:0]           rd_data
);

   localparam int AW = (PROFILE_LEN > 1) ? $clog2(PROFILE_LEN) : 1;
   localparam logic [16:0] DMAX = (DENSITY_BITS >= 17) ? 17'h1FFFF
                                  : 17'((64'd1 << DENSITY_BITS) - 64'd1);

   logic [15:0] line_mem [PROFILE_LEN];
   logic [15:0] rd_data_ff;

   logic [25:0] total_ff, total_in;
   logic [15:0] peak_ff, peak_in;
   logic        inb_ff, inb_in;
   logic [10:0] gap_ff, gap_in;
   logic [10:0] rw_ff, rw_in;
   logic [26:0] ws_ff, ws_in;
   logic [47:0] ms_ff, ms_in;
   logic [10:0] sc_ff, sc_in;
   logic        pend_ff;

   logic        accept;
   logic [25:0] total_b;
   logic [15:0] peak_b;
   logic        inb_b;
   logic [10:0] gap_b, rw_b, sc_b;
   logic [26:0] ws_b;
   logic [47:0] ms_b;
   logic [15:0] diff;
   logic [26:0] tsum;
   logic [16:0] v, fold, c2, pk;
   logic [27:0] wsum;
   logic [26:0] prod;
   logic [48:0] msum;
   logic [11:0] gsum;
   logic        close;

   assign req.ready = q_not_full && !pend_ff;
   assign accept    = req.valid && req.ready;
   assign push      = accept;

   // per-sample update
   always_comb begin
      total_b = req.pass_start ? '0 : total_ff;
      peak_b  = req.pass_start ? '0 : peak_ff;
      inb_b   = req.pass_start ? 1'b0 : inb_ff;
      gap_b   = req.pass_start ? '0 : gap_ff;
      rw_b    = req.pass_start ? '0 : rw_ff;
      ws_b    = req.pass_start ? '0 : ws_ff;
      ms_b    = req.pass_start ? '0 : ms_ff;
      sc_b    = req.pass_start ? '0 : sc_ff;

      total_in = total_b;
      pk       = {1'b0, peak_b};
      diff     = req.map_value - req.background_value;
      tsum     = {1'b0, total_b} + {11'd0, diff};
      fold     = cfg.double_peak - {1'b0, diff};
      v        = '0;
      if (req.map_value > req.background_value) begin
         total_in = (tsum > {1'b0, gtbd_pkg::SUM26_MAX}) ? gtbd_pkg::SUM26_MAX : tsum[25:0];
         if ({1'b0, diff} > pk) pk = {1'b0, diff};
         if (diff > cfg.filter_peak && cfg.double_peak > {1'b0, diff})
            v = (fold > DMAX) ? DMAX : fold;
         else
            v = {1'b0, diff};
      end

      c2   = v - {1'b0, cfg.band_floor};
      wsum = {1'b0, ws_b} + {11'd0, c2};
      prod = c2 * {7'd0, req.position};
      msum = {1'b0, ms_b} + {22'd0, prod};
      gsum = {1'b0, gap_b} + 12'd1;

      inb_in = inb_b;
      gap_in = gap_b;
      rw_in  = rw_b;
      ws_in  = ws_b;
      ms_in  = ms_b;
      sc_in  = sc_b;
      close  = 1'b0;
      if (v > {1'b0, cfg.band_floor}) begin
         ws_in  = (wsum > {1'b0, gtbd_pkg::SUM27_MAX}) ? gtbd_pkg::SUM27_MAX : wsum[26:0];
         ms_in  = (msum > {1'b0, gtbd_pkg::SUM48_MAX}) ? gtbd_pkg::SUM48_MAX : msum[47:0];
         sc_in  = (sc_b == gtbd_pkg::CNT11_MAX) ? sc_b : sc_b + 11'd1;
         rw_in  = (rw_b == gtbd_pkg::CNT11_MAX) ? rw_b : rw_b + 11'd1;
         if (c2 > pk) pk = c2;
         inb_in = 1'b1;
         gap_in = '0;
      end else begin
         gap_in = (gsum > {1'b0, gtbd_pkg::CNT11_MAX}) ? gtbd_pkg::CNT11_MAX : gsum[10:0];
         if (gap_in > {1'b0, cfg.gap_max} && inb_b) begin
            close  = 1'b1;
            inb_in = 1'b0;
            gap_in = '0;
            rw_in  = '0;
            ws_in  = '0;
            ms_in  = '0;
            sc_in  = '0;
         end else if (!inb_b) begin
            rw_in = '0;
         end
      end
      peak_in = (pk > 17'h0FFFF) ? 16'hFFFF : pk[15:0];

      push_job.pass_start   = req.pass_start;
      push_job.close        = close;
      push_job.weight_sum   = ws_b;
      push_job.moment_sum   = ms_b;
      push_job.sample_count = sc_b;
      push_job.run_width    = rw_b;
      push_job.total_sum    = total_in;
      push_job.running_peak = peak_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         peak_ff  <= '0;
         inb_ff   <= 1'b0;
         gap_ff   <= '0;
         rw_ff    <= '0;
         ws_ff    <= '0;
         ms_ff    <= '0;
         sc_ff    <= '0;
         pend_ff  <= 1'b0;
      end else begin
         if (accept) begin
            total_ff <= total_in;
            peak_ff  <= peak_in;
            inb_ff   <= inb_in;
            gap_ff   <= gap_in;
            rw_ff    <= rw_in;
            ws_ff    <= ws_in;
            ms_ff    <= ms_in;
            sc_ff    <= sc_in;
         end
         // hold off new samples until the back end has finished the close
         if (accept && close) pend_ff <= 1'b1;
         else if (close_done) pend_ff <= 1'b0;
      end
   end

   // line store: write on accept, registered read for the back end
   always_ff @(posedge clock) begin
      if (accept && (32'(req.position) < PROFILE_LEN))
         line_mem[AW'(req.position)] <= req.map_value;
      if (mem_req.rd_en)
         rd_data_ff <= (32'(mem_req.rd_addr) < PROFILE_LEN) ? line_mem[AW'(mem_req.rd_addr)]
                                                            : '0;
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/gtbd_back.sv */
// Back end (uses gtbd_pkg, gtbd_div): pops jobs, runs the mean division on
// blob close, the centroid if it stores a blob; holds the result register.
module gtbd_back #(
   parameter int BLOB_SLOTS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  gtbd_pkg::cfg_type     cfg,
   input  logic                  q_not_empty,
   input  gtbd_pkg::job_type     head_job,
   output logic                  pop,
   output logic                  close_done,
   output gtbd_pkg::mem_req_type mem_req,
   input  logic [15:0]           rd_data,
   gtbd_rsp_if.source            rsp
);

   localparam int SW = $clog2(BLOB_SLOTS + 1);

   gtbd_pkg::back_state_type state_ff, state_in;
   gtbd_pkg::job_type        job_ff, job_in;
   gtbd_pkg::rsp_type        rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [25:0]              filt_ff, filt_in;
   logic [SW-1:0]            stored_ff, stored_in;
   logic [15:0]              mean_ff, mean_in;
   logic [9:0]               loc_ff, loc_in;

   logic        div_start, div_done;
   logic [47:0] div_a, div_q;
   logic [26:0] div_b;
   logic        out_free;
   logic [26:0] fsum;
   logic [15:0] mean;
   logic [9:0]  loc;

   gtbd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gtbd_pkg::B_IDLE;
         rsp_valid_ff <= 1'b0;
         filt_ff      <= '0;
         stored_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         filt_ff      <= filt_in;
         stored_ff    <= stored_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      rsp_ff  <= rsp_in;
      mean_ff <= mean_in;
      loc_ff  <= loc_in;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      filt_in      = filt_ff;
      stored_in    = stored_ff;
      mean_in      = mean_ff;
      loc_in       = loc_ff;
      pop          = 1'b0;
      close_done   = 1'b0;
      div_start    = 1'b0;
      div_a        = {21'd0, head_job.weight_sum};
      div_b        = {16'd0, head_job.sample_count};
      mem_req      = '0;
      out_free     = !rsp_valid_ff || rsp.ready;
      mean         = (div_q > {32'd0, gtbd_pkg::MEAN_MAX}) ? gtbd_pkg::MEAN_MAX : div_q[15:0];
      loc          = (div_q > {38'd0, gtbd_pkg::LOC_MAX}) ? gtbd_pkg::LOC_MAX : div_q[9:0];
      fsum         = {1'b0, filt_ff} + {11'd0, mean};

      if (rsp_valid_ff && rsp.ready) rsp_valid_in = 1'b0;

      // default result: no blob, running figures only
      unique case (state_ff)
         gtbd_pkg::B_IDLE: begin
            if (q_not_empty && out_free) begin
               pop    = 1'b1;
               job_in = head_job;
               if (head_job.pass_start) begin
                  filt_in   = '0;
                  stored_in = '0;
               end
               if (head_job.close) begin
                  div_start = 1'b1;
                  state_in  = gtbd_pkg::B_MEAN;
               end else begin
                  rsp_in                 = '0;
                  rsp_in.density_total   = head_job.total_sum;
                  rsp_in.blob_mean_total = head_job.pass_start ? '0 : filt_ff;
                  rsp_in.peak_value      = head_job.running_peak;
                  rsp_valid_in           = 1'b1;
               end
            end
         end
         gtbd_pkg::B_MEAN: begin
            if (div_done) begin
               mean_in = mean;
               filt_in = (fsum > {1'b0, gtbd_pkg::SUM26_MAX}) ? gtbd_pkg::SUM26_MAX
                                                               : fsum[25:0];
               rsp_in                 = '0;
               rsp_in.density_total   = job_ff.total_sum;
               rsp_in.blob_mean_total = filt_in;
               rsp_in.peak_value      = job_ff.running_peak;
               if (mean > cfg.keep_threshold && stored_ff < SW'(BLOB_SLOTS)) begin
                  div_start = 1'b1;
                  div_a     = job_ff.moment_sum;
                  div_b     = job_ff.weight_sum;
                  state_in  = gtbd_pkg::B_LOC;
               end else begin
                  rsp_in.slots_full = (mean > cfg.keep_threshold);
                  rsp_valid_in      = 1'b1;
                  close_done        = 1'b1;
                  state_in          = gtbd_pkg::B_IDLE;
               end
            end
         end
         gtbd_pkg::B_LOC: begin
            if (div_done) begin
               loc_in          = loc;
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = loc;
               state_in        = gtbd_pkg::B_READ;
            end
         end
         gtbd_pkg::B_READ: begin
            rsp_in.blob_valid    = 1'b1;
            rsp_in.blob_slot     = 3'(stored_ff);
            rsp_in.blob_peak     = rd_data;
            rsp_in.blob_density  = mean_ff;
            rsp_in.blob_location = loc_ff;
            rsp_in.blob_width    = job_ff.run_width;
            rsp_valid_in         = 1'b1;
            stored_in            = stored_ff + SW'(1);
            close_done           = 1'b1;
            state_in             = gtbd_pkg::B_IDLE;
         end
         default: state_in = gtbd_pkg::B_IDLE;
      endcase
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.blob_valid      = rsp_ff.blob_valid;
   assign rsp.blob_slot       = rsp_ff.blob_slot;
   assign rsp.blob_peak       = rsp_ff.blob_peak;
   assign rsp.blob_density    = rsp_ff.blob_density;
   assign rsp.blob_location   = rsp_ff.blob_location;
   assign rsp.blob_width      = rsp_ff.blob_width;
   assign rsp.slots_full      = rsp_ff.slots_full;
   assign rsp.density_total   = rsp_ff.density_total;
   assign rsp.blob_mean_total = rsp_ff.blob_mean_total;
   assign rsp.peak_value      = rsp_ff.peak_value;

   // slot count never passes the slot total
   a_slots: assert property (@(posedge clock) disable iff (reset)
      32'(stored_ff) <= BLOB_SLOTS)
      else $error("slot count overflow");

   // divider is only launched from idle (mean) or after the mean (centroid)
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (state_ff == gtbd_pkg::B_IDLE || state_ff == gtbd_pkg::B_MEAN))
      else $error("divider started out of sequence");

   // busy states only serve a closing job
   a_close_job: assert property (@(posedge clock) disable iff (reset)
      state_ff != gtbd_pkg::B_IDLE |-> job_ff.close)
      else $error("back end busy without a blob close");

   // store read comes right after the centroid
   a_read_seq: assert property (@(posedge clock) disable iff (reset)
      state_ff == gtbd_pkg::B_READ |-> $past(state_ff == gtbd_pkg::B_LOC))
      else $error("line store read out of sequence");

endmodule

/* design/gap_tolerant_blob_detector.sv */
// Top level of the gap tolerant blob detector: configuration registers,
// front end, job queue and back end. Uses gtbd_pkg, gtbd_if and submodules.
//
// Usage:
//  req carries one profile sample per beat (pass_start, position, map_value,
//  background_value); rsp returns exactly one result beat per sample, in order.
//  Registers are written over the APB port (word i at byte 4*i); the user must
//  write them only while idle, which the block itself does not enforce.
//  A sample that does not close a blob has its result beat registered in the
//  job queue and then in the result register; one sample per cycle is
//  sustained while the receiver keeps ready high and no sample closes a blob.
//  A sample that closes a blob runs a 48-step serial division for the mean; a
//  stored blob adds the centroid division and one line store read.
//  The front end takes no further sample until the close is finished,
//  since later samples would overwrite the store.
//  A two-beat job queue lets the front keep accepting while the result
//  register waits on a stalled receiver; when the queue fills, req.ready
//  drops. Results stay stable until taken.
//  Reset clears all sums, blob state and slots and sets gap_max to 4; the
//  line store is not cleared and holds whatever was last written.
module gap_tolerant_blob_detector #(
   parameter int PROFILE_LEN  = 1024,
   parameter int BLOB_SLOTS   = 8,
   parameter int DENSITY_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   gtbd_req_if.sink    req,
   gtbd_rsp_if.source  rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   gtbd_pkg::cfg_type     cfg_ff;
   gtbd_pkg::job_type     push_job, head_job;
   gtbd_pkg::mem_req_type mem_req;
   logic                  push, pop, q_not_full, q_not_empty, close_done;
   logic [15:0]           rd_data;
   logic                  wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.filter_peak    <= '0;
         cfg_ff.double_peak    <= '0;
         cfg_ff.band_floor     <= '0;
         cfg_ff.gap_max        <= gtbd_pkg::GAP_MAX_RESET;
         cfg_ff.keep_threshold <= '0;
      end else if (wr_en) begin
         unique case (paddr[4:2])
            gtbd_pkg::REG_FILTER_PEAK: cfg_ff.filter_peak    <= pwdata[15:0];
            gtbd_pkg::REG_DOUBLE_PEAK: cfg_ff.double_peak    <= pwdata[16:0];
            gtbd_pkg::REG_BAND_FLOOR:  cfg_ff.band_floor     <= pwdata[15:0];
            gtbd_pkg::REG_GAP_MAX:     cfg_ff.gap_max        <= pwdata[9:0];
            gtbd_pkg::REG_MIN_DENSITY: cfg_ff.keep_threshold <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      unique case (paddr[4:2])
         gtbd_pkg::REG_FILTER_PEAK: prdata = {16'd0, cfg_ff.filter_peak};
         gtbd_pkg::REG_DOUBLE_PEAK: prdata = {15'd0, cfg_ff.double_peak};
         gtbd_pkg::REG_BAND_FLOOR:  prdata = {16'd0, cfg_ff.band_floor};
         gtbd_pkg::REG_GAP_MAX:     prdata = {22'd0, cfg_ff.gap_max};
         gtbd_pkg::REG_MIN_DENSITY: prdata = {16'd0, cfg_ff.keep_threshold};
         default:                   prdata = '0;
      endcase
   end

   gtbd_front #(
      .PROFILE_LEN  (PROFILE_LEN),
      .DENSITY_BITS (DENSITY_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .cfg        (cfg_ff),
      .push       (push),
      .push_job   (push_job),
      .q_not_full (q_not_full),
      .close_done (close_done),
      .mem_req    (mem_req),
      .rd_data    (rd_data)
   );

   gtbd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .not_full  (q_not_full),
      .pop       (pop),
      .not_empty (q_not_empty),
      .head_job  (head_job)
   );

   gtbd_back #(
      .BLOB_SLOTS (BLOB_SLOTS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_not_empty (q_not_empty),
      .head_job    (head_job),
      .pop         (pop),
      .close_done  (close_done),
      .mem_req     (mem_req),
      .rd_data     (rd_data),
      .rsp         (rsp)
   );

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the gap tolerant blob detector.
// Drives profile sample beats, predicts each result beat in a scoreboard model
// and compares field by field. Depends on gtbd_pkg, gtbd_if and the RTL top.
`timescale 1ns / 1ps

module tb_top;

   localparam int PROFILE_LEN = 1024;
   localparam int BLOB_SLOTS  = 8;
   localparam longint CYCLE_LIMIT = 3000000;

   typedef struct packed {
      logic        pass_start;
      logic [9:0]  position;
      logic [15:0] map_value;
      logic [15:0] background_value;
   } sample_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [4:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   gtbd_req_if req ();
   gtbd_rsp_if rsp ();

   gap_tolerant_blob_detector u_top (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Stimulus and expectation stores
   sample_type        sample_q[$];
   gtbd_pkg::rsp_type expected_q[$];
   int   errors = 0;
   int   blobs_seen = 0, full_seen = 0;
   int   sent = 0, taken = 0;
   int   src_idle_pct = 0, snk_idle_pct = 0;
   int   hold_cycles = 0;
   longint cycle_count = 0;

   // Predictor state
   gtbd_pkg::cfg_type cfg;
   logic [15:0] line_mem [PROFILE_LEN];
   logic [25:0] tot_sum, filt_sum;
   logic [15:0] peak_run;
   logic        open_blob;
   logic [10:0] gap_cnt, run_wid, samp_cnt;
   logic [26:0] wt_sum;
   logic [47:0] mom_sum;
   int          slots_used;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned sat(longint unsigned a, longint unsigned lim);
      return (a > lim) ? lim : a;
   endfunction

   function automatic void clear_open_blob();
      open_blob = 1'b0; gap_cnt = '0; run_wid = '0; wt_sum = '0; mom_sum = '0;
      samp_cnt = '0;
   endfunction

   function automatic void clear_pass_state();
      tot_sum = '0; filt_sum = '0; peak_run = '0; slots_used = 0;
      clear_open_blob();
   endfunction

   // Compute the result beat one sample causes and update the predictor
   function automatic gtbd_pkg::rsp_type detect_blob(sample_type s);
      gtbd_pkg::rsp_type r;
      longint unsigned v, c2, mean, loc, rp;
      r = '0;
      rp = 64'(peak_run);
      if (s.pass_start) begin
         clear_pass_state();
         rp = 0;
      end
      line_mem[s.position] = s.map_value;
      if (s.map_value > s.background_value) begin
         v = 64'(s.map_value) - 64'(s.background_value);
         tot_sum = 26'(sat(64'(tot_sum) + v, 64'(gtbd_pkg::SUM26_MAX)));
         if (v > rp) rp = v;
         if (v > 64'(cfg.filter_peak) && 64'(cfg.double_peak) > v) begin
            v = 64'(cfg.double_peak) - v;
            if (v > 64'd65535) v = 64'd65535;
         end
      end else v = 0;
      if (v > 64'(cfg.band_floor)) begin
         c2 = v - 64'(cfg.band_floor);
         wt_sum = 27'(sat(64'(wt_sum) + c2, 64'(gtbd_pkg::SUM27_MAX)));
         mom_sum = 48'(sat(64'(mom_sum) + c2 * 64'(s.position), 64'(gtbd_pkg::SUM48_MAX)));
         samp_cnt = 11'(sat(64'(samp_cnt) + 64'd1, 64'(gtbd_pkg::CNT11_MAX)));
         if (c2 > rp) rp = c2;
         run_wid = 11'(sat(64'(run_wid) + 64'd1, 64'(gtbd_pkg::CNT11_MAX)));
         open_blob = 1'b1;
         gap_cnt = '0;
      end else begin
         gap_cnt = 11'(sat(64'(gap_cnt) + 64'd1, 64'(gtbd_pkg::CNT11_MAX)));
         if (gap_cnt > {1'b0, cfg.gap_max} && open_blob) begin
            mean = (samp_cnt != '0) ? 64'(wt_sum) / 64'(samp_cnt) : 64'd0;
            if (mean > 64'd65535) mean = 64'd65535;
            filt_sum = 26'(sat(64'(filt_sum) + mean, 64'(gtbd_pkg::SUM26_MAX)));
            if (mean > 64'(cfg.keep_threshold)) begin
               loc = (wt_sum != '0) ? 64'(mom_sum) / 64'(wt_sum) : 64'd0;
               if (loc > 64'd1023) loc = 64'd1023;
               if (slots_used < BLOB_SLOTS) begin
                  r.blob_valid = 1'b1;
                  r.blob_slot = 3'(slots_used);
                  r.blob_peak = line_mem[10'(loc)];
                  r.blob_density = 16'(mean);
                  r.blob_location = 10'(loc);
                  r.blob_width = run_wid;
                  slots_used++;
               end else r.slots_full = 1'b1;
            end
            clear_open_blob();
         end else if (!open_blob) run_wid = '0;
      end
      if (rp > 64'd65535) rp = 64'd65535;
      peak_run = 16'(rp);
      r.density_total = tot_sum;
      r.blob_mean_total = filt_sum;
      r.peak_value = peak_run;
      return r;
   endfunction

   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      $display("MISMATCH beat %0d %s: got %0h expected %0h", taken, what, got, want);
      errors++;
   endtask

   // Driver: offers queued samples; the model runs at acceptance
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else begin
         if (req.valid && req.ready) begin
            expected_q.push_back(detect_blob(sample_q.pop_front()));
            sent++;
         end
         if (req.valid && !req.ready) begin
            // hold the waiting beat unchanged
         end else if (sample_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
            req.valid <= 1'b1;
            req.pass_start <= sample_q[0].pass_start;
            req.position <= sample_q[0].position;
            req.map_value <= sample_q[0].map_value;
            req.background_value <= sample_q[0].background_value;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // Receiver ready, with an optional long hold-off counted here
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
   end

   // Monitor: compares each result beat with the oldest expectation
   always @(posedge clock) begin
      gtbd_pkg::rsp_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected beat", 1, 0);
         end else begin
            e = expected_q.pop_front();
            if (rsp.blob_valid !== e.blob_valid)
               report_mismatch("blob_valid", rsp.blob_valid, e.blob_valid);
            if (rsp.blob_slot !== e.blob_slot)
               report_mismatch("blob_slot", rsp.blob_slot, e.blob_slot);
            if (rsp.blob_peak !== e.blob_peak)
               report_mismatch("blob_peak", rsp.blob_peak, e.blob_peak);
            if (rsp.blob_density !== e.blob_density)
               report_mismatch("blob_density", rsp.blob_density, e.blob_density);
            if (rsp.blob_location !== e.blob_location)
               report_mismatch("blob_location", rsp.blob_location, e.blob_location);
            if (rsp.blob_width !== e.blob_width)
               report_mismatch("blob_width", rsp.blob_width, e.blob_width);
            if (rsp.slots_full !== e.slots_full)
               report_mismatch("slots_full", rsp.slots_full, e.slots_full);
            if (rsp.density_total !== e.density_total)
               report_mismatch("density_total", rsp.density_total, e.density_total);
            if (rsp.blob_mean_total !== e.blob_mean_total)
               report_mismatch("blob_mean_total", rsp.blob_mean_total,
                               e.blob_mean_total);
            if (rsp.peak_value !== e.peak_value)
               report_mismatch("peak_value", rsp.peak_value, e.peak_value);
            blobs_seen += int'(e.blob_valid);
            full_seen += int'(e.slots_full);
         end
         taken <= taken + 1;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Register write over the APB port; the model copy follows it
   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      @(posedge clock);
      psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      case (idx)
         gtbd_pkg::REG_FILTER_PEAK: cfg.filter_peak = val[15:0];
         gtbd_pkg::REG_DOUBLE_PEAK: cfg.double_peak = val[16:0];
         gtbd_pkg::REG_BAND_FLOOR:  cfg.band_floor = val[15:0];
         gtbd_pkg::REG_GAP_MAX:     cfg.gap_max = val[9:0];
         gtbd_pkg::REG_MIN_DENSITY: cfg.keep_threshold = val[15:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      while (sample_q.size() > 0 || expected_q.size() > 0 || req.valid) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic push_sample(bit ps, int pos, int mapv, int bgv);
      sample_type s;
      s.pass_start = ps;
      s.position = 10'(pos);
      s.map_value = 16'(mapv);
      s.background_value = 16'(bgv);
      sample_q.push_back(s);
   endtask

   // Closing a blob reads the store at its centroid: all positions a centroid can
   // land on lie between written ones, so each pass first writes the span in use.
   task automatic prime_span(int lo, int hi);
      for (int p = lo; p <= hi; p++) push_sample(p == lo, p, $urandom_range(65535), 65535);
   endtask

   // One pass of random blobs and gaps over a contiguous span
   task automatic random_pass(int lo, int span);
      int p;
      p = lo;
      prime_span(lo, lo + span - 1);
      while (p < lo + span) begin
         case ($urandom_range(9))
            0, 1, 2, 3: push_sample(0, p, $urandom_range(65535), $urandom_range(2000));
            4: push_sample(0, p, 65535, 0);
            5: push_sample(0, p, $urandom_range(300), $urandom_range(65535));
            default: push_sample(0, p, $urandom_range(1000), $urandom_range(1000));
         endcase
         p++;
      end
   endtask

   task automatic random_cfg();
      write_reg(gtbd_pkg::REG_FILTER_PEAK,
                $urandom_range(3) == 0 ? 65535 : $urandom_range(65535));
      write_reg(gtbd_pkg::REG_DOUBLE_PEAK,
                $urandom_range(3) == 0 ? 131071 : $urandom_range(131071));
      write_reg(gtbd_pkg::REG_BAND_FLOOR, $urandom_range(1) ? $urandom_range(2000)
                                                            : $urandom_range(65535));
      write_reg(gtbd_pkg::REG_GAP_MAX, $urandom_range(3) == 0 ? 0 : $urandom_range(6));
      write_reg(gtbd_pkg::REG_MIN_DENSITY, $urandom_range(1) ? 0 : $urandom_range(20000));
   endtask

   initial begin
      int passes;
      cfg = '0;
      cfg.gap_max = gtbd_pkg::GAP_MAX_RESET;
      clear_pass_state();
      req.valid = 0; req.pass_start = 0; req.position = 0;
      req.map_value = 0; req.background_value = 0;
      rsp.ready = 0;
      repeat (12) @(posedge clock);
      reset <= 0;

      // Directed: field extremes, folding, saturation, slot overflow
      write_reg(gtbd_pkg::REG_FILTER_PEAK, 100);
      write_reg(gtbd_pkg::REG_DOUBLE_PEAK, 131071);
      write_reg(gtbd_pkg::REG_BAND_FLOOR, 0);
      write_reg(gtbd_pkg::REG_GAP_MAX, 0);
      write_reg(gtbd_pkg::REG_MIN_DENSITY, 0);
      push_sample(1, 0, 65535, 0);     // fold saturates
      push_sample(0, 1, 0, 65535);     // closes blob at position 0
      push_sample(0, 1023, 65535, 0);
      push_sample(0, 1022, 0, 0);      // closes blob at top position
      for (int i = 0; i < 9; i++) begin
         push_sample(0, 2 + 2 * i, 50, 10);
         push_sample(0, 3 + 2 * i, 5, 5);  // closes past the last slot find none
      end
      push_sample(1, 1023, 65535, 1);
      push_sample(0, 1022, 65535, 65535);
      drain();
      write_reg(gtbd_pkg::REG_FILTER_PEAK, 65535);
      write_reg(gtbd_pkg::REG_DOUBLE_PEAK, 0);
      write_reg(gtbd_pkg::REG_BAND_FLOOR, 65535);
      write_reg(gtbd_pkg::REG_GAP_MAX, 1023);
      write_reg(gtbd_pkg::REG_MIN_DENSITY, 65535);
      push_sample(1, 5, 65535, 0);
      push_sample(0, 6, 65535, 0);
      drain();

      // Random phases, three idling profiles
      passes = 0;
      for (int ph = 0; ph < 3; ph++) begin
         src_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 85 : 0;
         snk_idle_pct = (ph == 0) ? 85 : (ph == 1) ? 18 : 0;
         while (passes < 10 * (ph + 1)) begin
            random_cfg();
            random_pass(int'($urandom_range(900)), 8 + int'($urandom_range(48)));
            if (ph == 2 && passes == 25) hold_cycles = 400;
            drain();
            passes++;
         end
      end

      $display("Covered %0d samples with %0d stored blobs and %0d slot overflows,",
               sent, blobs_seen, full_seen);
      $display("across three idle profiles and %0d register settings.", passes + 2);
      if (errors == 0 && expected_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* files.f */
design/gtbd_pkg.sv
design/gtbd_if.sv
design/gtbd_div.sv
design/gtbd_queue.sv
design/gtbd_front.sv
design/gtbd_back.sv
design/gap_tolerant_blob_detector.sv
verif/tb_top.sv
